[sv/warma_pkg.sv]
// Package for the wrapped angle rate moving average block.
// Types, widths and constants shared by the interfaces and the top level.
`default_nettype none

package warma_pkg;

  // Window length of the moving average; must be a power of two because
  // the floor division is an arithmetic shift.
  localparam int unsigned Window     = 8;
  localparam int unsigned WindowLog2 = $clog2(Window);

  localparam int unsigned YawW   = 16;
  localparam int unsigned CrateW = 10;
  localparam int unsigned RateW  = 26;
  localparam int unsigned DiffW  = YawW + 2;  // room for diff +/- two turns
  localparam int unsigned TotalW = 32;
  localparam int unsigned ProdW  = YawW + CrateW + 1;

  localparam logic signed [DiffW-1:0] HalfTurn  = DiffW'(18000);
  localparam logic signed [DiffW-1:0] FullTurn  = DiffW'(36000);
  localparam logic signed [DiffW-1:0] TwoTurns  = DiffW'(72000);
  localparam logic signed [DiffW-1:0] ThreeHalf = DiffW'(54000);

  localparam logic [CrateW-1:0] CrateReset = CrateW'(100);

  typedef logic signed [YawW-1:0]   yaw_t;
  typedef logic signed [DiffW-1:0]  diff_t;
  typedef logic        [CrateW-1:0] crate_t;
  typedef logic signed [RateW-1:0]  rate_t;
  typedef logic signed [TotalW-1:0] total_t;
  typedef logic signed [ProdW-1:0]  prod_t;

endpackage : warma_pkg

`default_nettype wire

[sv/warma_in_if.sv]
// Input channel of the wrapped angle rate moving average block.
// Carries one yaw sample per transfer; uses warma_pkg.
`default_nettype none

interface warma_in_if import warma_pkg::*; ();
  logic valid;
  logic ready;
  yaw_t yaw_in;

  modport source (output valid, output yaw_in, input ready);
  modport sink   (input valid, input yaw_in, output ready);
endinterface : warma_in_if

`default_nettype wire

[sv/warma_out_if.sv]
// Result channel of the wrapped angle rate moving average block.
// Carries raw and filtered rate per transfer; uses warma_pkg.
`default_nettype none

interface warma_out_if import warma_pkg::*; ();
  logic  valid;
  logic  ready;
  rate_t raw_rate;
  rate_t filtered_rate;

  modport source (output valid, output raw_rate, output filtered_rate, input ready);
  modport sink   (input valid, input raw_rate, input filtered_rate, output ready);
endinterface : warma_out_if

`default_nettype wire

[sv/wrapped_angle_rate_moving_average.sv]
// Top level: yaw rate estimator with moving-average smoothing.
// Depends on warma_pkg, warma_in_if and warma_out_if.
//
// Usage:
//  - sample_i (valid/ready) takes one yaw sample in 0.01 deg per transfer.
//  - result_o (valid/ready) returns one result per sample: raw_rate, the
//    wrapped angle step times control_rate, and filtered_rate, the floor of
//    the mean of the last Window raw rates.
//  - cfg_we_i/cfg_wdata_i write control_rate (Hz); write only while idle.
//  - Three register stages: wrap step, multiply, window update + result
//    register. A sample passes step_q, raw_q, then the output registers
//    to reach result_o. Throughput is one sample per cycle unless result_o
//    stalls, set by the single multiplier stage and the running-sum update.
//  - Each stage has its own valid bit and advances when the stage after it
//    is empty or moving, so a stalled result does not block bubbles ahead
//    of it from filling; ready drops only once all three stages are full.
//  - Reset (rst_ni low, async): previous yaw, window and running sum go to
//    zero, control_rate to 100, all stages empty.
`default_nettype none

module wrapped_angle_rate_moving_average
  import warma_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  warma_in_if.sink        sample_i,
  warma_out_if.source     result_o,
  input  wire logic       cfg_we_i,
  input  wire crate_t     cfg_wdata_i
);

  // stage enables, back to front
  logic en1, en2, en3;

  logic   v1_q, v2_q, v3_q;
  crate_t crate_q;
  yaw_t   prev_yaw_q;
  yaw_t   step_q;
  rate_t  raw_q;
  rate_t  out_raw_q, out_filt_q;
  rate_t  win_q [Window];
  total_t total_q;

  diff_t  diff;
  diff_t  wrapped;
  prod_t  prod;
  total_t total_d;

  assign en3 = !v3_q || result_o.ready;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign sample_i.ready         = en1;
  assign result_o.valid         = v3_q;
  assign result_o.raw_rate      = out_raw_q;
  assign result_o.filtered_rate = out_filt_q;

  // Stage 1: difference to the previous sample, wrapped into (-18000, 18000].
  always_comb begin
    diff = DiffW'(sample_i.yaw_in) - DiffW'(prev_yaw_q);
    if (diff > ThreeHalf) begin
      wrapped = diff - TwoTurns;
    end else if (diff > HalfTurn) begin
      wrapped = diff - FullTurn;
    end else if (diff <= -ThreeHalf) begin
      wrapped = diff + TwoTurns;
    end else if (diff <= -HalfTurn) begin
      wrapped = diff + FullTurn;
    end else begin
      wrapped = diff;
    end
  end

  // Stage 2: scale by control rate; |product| <= 18000*1023 fits RateW.
  assign prod = ProdW'(step_q) * ProdW'(signed'({1'b0, crate_q}));

  // Stage 3: running sum drops the oldest entry, adds the newest.
  assign total_d = total_q + TotalW'(raw_q) - TotalW'(win_q[Window-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crate_q    <= CrateReset;
      prev_yaw_q <= '0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      v3_q       <= 1'b0;
      total_q    <= '0;
      for (int i = 0; i < Window; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        crate_q <= cfg_wdata_i;
      end
      if (en1) begin
        v1_q <= sample_i.valid;
        if (sample_i.valid) begin
          prev_yaw_q <= sample_i.yaw_in;
        end
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
        if (v2_q) begin
          total_q  <= total_d;
          win_q[0] <= raw_q;
          for (int i = 1; i < Window; i++) begin
            win_q[i] <= win_q[i-1];
          end
        end
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (en1) begin
      step_q <= YawW'(wrapped);
    end
    if (en2) begin
      raw_q <= RateW'(prod);
    end
    if (en3) begin
      out_raw_q  <= raw_q;
      out_filt_q <= RateW'(total_d >>> WindowLog2);  // floor of mean
    end
  end

endmodule : wrapped_angle_rate_moving_average

`default_nettype wire
